/* sv/assert_macros.svh */
// Assertion macros shared by the RTL.
// Depends on nothing; included inside module bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`endif

/* sv/srrb_pkg.sv */
// Package for the stereo resampling ring buffer: constants, codes, payload types.
// Depends on nothing.
`timescale 1ns / 1ps
package srrb_pkg;
  localparam int RingFrames  = 4096;
  localparam int RingAw      = $clog2(RingFrames);
  localparam int MaxUpsample = 48;
  localparam int RateW       = 19;
  localparam logic [31:0] PhaseOne = 32'h0100_0000;
  localparam logic [RateW-1:0] OutRateRst = RateW'(48000);

  typedef enum logic [1:0] {
    CMD_PUSH  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [1:0]        cmd;
    logic signed [15:0] sample_left;
    logic signed [15:0] sample_right;
    logic              is_mono;
    logic [RateW-1:0]  input_rate;
    logic              packet_start;
    logic              discontinuity;
  } in_item_t;

  typedef struct packed {
    logic              pop_valid;
    logic signed [15:0] out_left;
    logic signed [15:0] out_right;
    logic [5:0]        frames_written;
    logic              overflowed;
    logic [31:0]       overflow_total;
    logic [12:0]       fill_level;
  } out_item_t;

  // lerp: a + floor(((b - a) * ph + 2^23) / 2^24); ph below 2^24 here
  function automatic logic signed [15:0] lerp(input logic signed [15:0] a,
                                              input logic signed [15:0] b,
                                              input logic [23:0] ph);
    logic signed [16:0] d;
    logic signed [42:0] p;
    d = 17'(b) - 17'(a);
    p = 43'(d) * $signed({1'b0, ph}) + 43'sd8388608;
    return 16'(17'(a) + 17'(p >>> 24));
  endfunction
endpackage

/* sv/srrb_div.sv */
// Restoring divider: floor((rate << 24) / out_rate), one quotient bit a cycle.
// Depends on srrb_pkg.
`timescale 1ns / 1ps
module srrb_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [srrb_pkg::RateW-1:0] num_i,
  input  logic [srrb_pkg::RateW-1:0] den_i,
  output logic                      done_o,
  output logic [42:0]               quot_o
);
  import srrb_pkg::*;
  localparam int NumW = RateW + 24;

  logic [NumW-1:0] quot_q, quot_d;
  logic [RateW:0]  rem_q, rem_d;
  logic [RateW-1:0] den_q, den_d;
  logic [5:0]      cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic [RateW:0]  trial;

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = '0;
    if (start_i) begin
      quot_d = {num_i, 24'd0};
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = 6'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      trial = {rem_q[RateW-1:0], quot_q[NumW-1]};
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quot_d = {quot_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quot_d = {quot_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
  end

  assign done_o = busy_q && (cnt_q == 6'd1);
  assign quot_o = quot_d;
endmodule

/* sv/stereo_resampling_ring_buffer.sv */
// Stereo resampling ring buffer: command input, one status item out per command.
// Channels: in_valid_i/in_ready_o with in_item_i (srrb_pkg::in_item_t), and
// out_valid_o/out_ready_i with out_item_o (srrb_pkg::out_item_t). output_rate
// sits behind an APB-style port at address 0, always ready.
// Every command gives exactly one result item. States from acceptance to the
// result: clear, unknown commands and ignored pushes go straight to ST_DONE,
// passthrough pushes pass ST_LOOP, pops on an empty ring ST_RDWT, other pops
// ST_RDWT and ST_RDDAT. A resampled push first runs the bit-serial step
// divider (ST_DIV); a priming push then gives its result, otherwise one
// interpolated frame is written per cycle into the 4096-frame ring memory, at
// most 49 frames. One item is worked on at a time. A pop reads the ring memory
// through its registered read port.
// The result sits in an output register; the next item is taken while it
// waits, and the block holds before the next result until the receiver takes
// the previous one.
// Reset clears counters, interpolator state and output_rate (to 48000); the
// ring memory is not cleared and an unwritten entry is never returned in a result.
`timescale 1ns / 1ps
module stereo_resampling_ring_buffer (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  srrb_pkg::in_item_t   in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output srrb_pkg::out_item_t  out_item_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [1:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import srrb_pkg::*;
  `include "assert_macros.svh"

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_DIV   = 6'b000010,
    ST_LOOP  = 6'b000100,
    ST_RDWT  = 6'b001000,
    ST_RDDAT = 6'b010000,
    ST_DONE  = 6'b100000
  } state_e;

  state_e state_q, state_d;
  in_item_t item_q, item_d;
  logic [RateW-1:0] out_rate_q;
  logic [31:0] wr_cnt_q, wr_cnt_d, rd_cnt_q, rd_cnt_d, disc_q, disc_d;
  logic have_prev_q, have_prev_d;
  logic signed [15:0] prev_l_q, prev_l_d, prev_r_q, prev_r_d;
  logic [31:0] phase_q, phase_d, step_q, step_d;
  logic [RateW-1:0] cin_q, cin_d, cout_q, cout_d;
  logic dropped_q, dropped_d;
  logic [31:0] ovf_cnt_q, ovf_cnt_d;
  logic [5:0] written_q, written_d;
  logic ovf_q, ovf_d;
  logic pv_q, pv_d;
  logic out_valid_q, out_valid_d;
  out_item_t out_q, out_d;

  logic [31:0] mem [RingFrames];
  logic [31:0] rdata_q;
  logic mem_we;
  logic [RingAw-1:0] mem_waddr;
  logic [31:0] mem_wdata;

  logic div_start, div_done;
  logic [42:0] div_quot;

  // divider loads its operands only at start, which happens on acceptance
  srrb_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (in_item_i.input_rate),
    .den_i   (out_rate_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // APB register
  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {13'd0, out_rate_q} : 32'd0;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_rate_q <= OutRateRst;
    end else if (psel && penable && pwrite && paddr == 2'd0) begin
      out_rate_q <= pwdata[RateW-1:0];
    end
  end

  // read once per pop, at the address after the discard skip; held until next pop
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (state_q == ST_RDWT) rdata_q <= mem[rd_cnt_d[RingAw-1:0]];
  end

  logic signed [15:0] cur_l, cur_r;
  logic full;
  logic [31:0] fa, fb;
  logic [32:0] np;
  logic signed [15:0] il, ir;

  assign cur_l = item_q.sample_left;
  assign cur_r = item_q.is_mono ? item_q.sample_left : item_q.sample_right;
  assign full  = (wr_cnt_q - rd_cnt_q) >= 32'(RingFrames);
  assign il = lerp(prev_l_q, cur_l, phase_q[23:0]);
  assign ir = lerp(prev_r_q, cur_r, phase_q[23:0]);
  assign in_ready_o = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o = out_q;

  always_comb begin
    state_d = state_q;
    item_d = item_q;
    wr_cnt_d = wr_cnt_q; rd_cnt_d = rd_cnt_q; disc_d = disc_q;
    have_prev_d = have_prev_q; prev_l_d = prev_l_q; prev_r_d = prev_r_q;
    phase_d = phase_q; step_d = step_q; cin_d = cin_q; cout_d = cout_q;
    dropped_d = dropped_q; ovf_cnt_d = ovf_cnt_q;
    written_d = written_q; ovf_d = ovf_q; pv_d = pv_q;
    out_valid_d = out_valid_q; out_d = out_q;
    mem_we = 1'b0;
    mem_waddr = wr_cnt_q[RingAw-1:0];
    mem_wdata = {cur_l, cur_r};
    div_start = 1'b0;
    np = '0;
    fa = '0; fb = '0;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          item_d = in_item_i;
          written_d = '0; ovf_d = 1'b0; pv_d = 1'b0;
          state_d = ST_DONE;
          unique case (cmd_e'(in_item_i.cmd))
            CMD_PUSH: begin
              logic dr;
              dr = dropped_q;
              if (in_item_i.packet_start) begin
                dr = 1'b0;
                if (in_item_i.discontinuity) begin
                  have_prev_d = 1'b0; phase_d = '0; cin_d = '0; cout_d = '0;
                end
              end
              dropped_d = dr;
              if (in_item_i.input_rate != '0 && out_rate_q != '0 && !dr) begin
                if (in_item_i.input_rate == out_rate_q) begin
                  have_prev_d = 1'b0; phase_d = '0; cin_d = '0; cout_d = '0;
                  // passthrough write done in ST_LOOP
                  state_d = ST_LOOP;
                end else begin
                  div_start = 1'b1;
                  state_d = ST_DIV;
                end
              end
            end
            CMD_POP: state_d = ST_RDWT;
            CMD_CLEAR: begin
              disc_d = wr_cnt_q;
              have_prev_d = 1'b0; phase_d = '0; cin_d = '0; cout_d = '0;
            end
            default: ;
          endcase
        end
      end
      ST_DIV: begin
        if (div_done) begin
          step_d = (div_quot[42:32] != '0) ? 32'hFFFF_FFFF : div_quot[31:0];
          if (cin_q != item_q.input_rate || cout_q != out_rate_q) begin
            // new rate: first frame only primes
            cin_d = item_q.input_rate; cout_d = out_rate_q;
            phase_d = '0;
            have_prev_d = 1'b1;
            prev_l_d = cur_l; prev_r_d = cur_r;
            state_d = ST_DONE;
          end else if (!have_prev_q) begin
            have_prev_d = 1'b1;
            prev_l_d = cur_l; prev_r_d = cur_r;
            state_d = ST_DONE;
          end else begin
            state_d = ST_LOOP;
          end
        end
      end
      ST_LOOP: begin
        if (item_q.input_rate == out_rate_q) begin
          // passthrough frame
          if (full) begin
            ovf_d = 1'b1; ovf_cnt_d = ovf_cnt_q + 32'd1; dropped_d = 1'b1;
          end else begin
            mem_we = 1'b1; wr_cnt_d = wr_cnt_q + 32'd1; written_d = 6'd1;
          end
          state_d = ST_DONE;
        end else if (phase_q >= PhaseOne) begin
          phase_d = phase_q - PhaseOne;
          prev_l_d = cur_l; prev_r_d = cur_r;
          state_d = ST_DONE;
        end else if (written_q == 6'(MaxUpsample + 1)) begin
          phase_d = '0;
          prev_l_d = cur_l; prev_r_d = cur_r;
          state_d = ST_DONE;
        end else if (full) begin
          ovf_d = 1'b1; ovf_cnt_d = ovf_cnt_q + 32'd1; dropped_d = 1'b1;
          state_d = ST_DONE;
        end else begin
          mem_we = 1'b1;
          mem_wdata = {il, ir};
          wr_cnt_d = wr_cnt_q + 32'd1;
          written_d = written_q + 6'd1;
          np = {1'b0, phase_q} + {1'b0, step_q};
          phase_d = np[32] ? 32'hFFFF_FFFF : np[31:0];
        end
      end
      ST_RDWT: begin
        if ((wr_cnt_q - rd_cnt_q) > (wr_cnt_q - disc_q)) rd_cnt_d = disc_q;
        state_d = ST_RDDAT;
        if (rd_cnt_d == wr_cnt_q) state_d = ST_DONE;
      end
      ST_RDDAT: begin
        // rdata_q was read at the end of ST_RDWT
        pv_d = 1'b1;
        rd_cnt_d = rd_cnt_q + 32'd1;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          fa = wr_cnt_q - rd_cnt_q;
          fb = wr_cnt_q - disc_q;
          out_d.pop_valid = pv_q;
          out_d.out_left = pv_q ? rdata_q[31:16] : '0;
          out_d.out_right = pv_q ? rdata_q[15:0] : '0;
          out_d.frames_written = written_q;
          out_d.overflowed = ovf_q;
          out_d.overflow_total = ovf_cnt_q;
          out_d.fill_level = (fa < fb) ? fa[12:0] : fb[12:0];
          out_valid_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      wr_cnt_q <= '0; rd_cnt_q <= '0; disc_q <= '0;
      have_prev_q <= 1'b0; prev_l_q <= '0; prev_r_q <= '0;
      phase_q <= '0; step_q <= '0; cin_q <= '0; cout_q <= '0;
      dropped_q <= 1'b0; ovf_cnt_q <= '0;
      written_q <= '0; ovf_q <= 1'b0; pv_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      wr_cnt_q <= wr_cnt_d; rd_cnt_q <= rd_cnt_d; disc_q <= disc_d;
      have_prev_q <= have_prev_d; prev_l_q <= prev_l_d; prev_r_q <= prev_r_d;
      phase_q <= phase_d; step_q <= step_d; cin_q <= cin_d; cout_q <= cout_d;
      dropped_q <= dropped_d; ovf_cnt_q <= ovf_cnt_d;
      written_q <= written_d; ovf_q <= ovf_d; pv_q <= pv_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    out_q <= out_d;
  end

  `ASSERT_IMPL(a_fill_bound, clk_i, rst_ni, 1'b1,
               (wr_cnt_q - rd_cnt_q) <= 32'(RingFrames), "ring over capacity")
  `ASSERT_IMPL(a_wr_not_full, clk_i, rst_ni, mem_we, !full, "write into full ring")
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_q && !out_ready_i,
               out_valid_q && $stable(out_q), "result lost under stall")
  `ASSERT_IMPL(a_loop_cap, clk_i, rst_ni, state_q == ST_LOOP,
               written_q <= 6'(MaxUpsample + 1), "upsample cap exceeded")
endmodule

/* tb/testbench.sv */
// Testbench for the stereo resampling ring buffer: random and directed commands,
// predicted results checked item by item. Depends on srrb_pkg and the block RTL.
`timescale 1ns / 1ps
module testbench;
  import srrb_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_item_t in_item_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_item_t out_item_o;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  stereo_resampling_ring_buffer dut (.*);

  always #5 clk_i = ~clk_i;

  // predictor state
  logic signed [15:0] ring_l [RingFrames];
  logic signed [15:0] ring_r [RingFrames];
  logic [RateW-1:0] out_rate;
  logic [31:0] wr_cnt, rd_cnt, discard_at;
  logic have_prev;
  logic signed [15:0] prev_l, prev_r;
  logic [31:0] phase, step;
  logic [RateW-1:0] last_in_rate, last_out_rate;
  logic drop_pkt;
  logic [31:0] ovf_cnt;

  in_item_t pending_cmds[$];
  out_item_t expected_status[$];
  int mismatches = 0;

  function automatic logic signed [15:0] interp(logic signed [15:0] a,
                                                logic signed [15:0] b, logic [31:0] ph);
    longint d, p;
    d = longint'(b) - longint'(a);
    p = d * longint'(ph) + 64'sd8388608;
    return 16'(longint'(a) + (p >>> 24));
  endfunction

  function automatic void clear_interp();
    have_prev = 1'b0;
    phase = '0;
    last_in_rate = '0;
    last_out_rate = '0;
  endfunction

  function automatic logic [31:0] readable();
    logic [31:0] a, b;
    a = wr_cnt - rd_cnt;
    b = wr_cnt - discard_at;
    return a < b ? a : b;
  endfunction

  function automatic bit store_frame(logic signed [15:0] l, logic signed [15:0] r);
    if (wr_cnt - rd_cnt >= RingFrames) return 1'b0;
    ring_l[wr_cnt % RingFrames] = l;
    ring_r[wr_cnt % RingFrames] = r;
    wr_cnt++;
    return 1'b1;
  endfunction

  function automatic out_item_t predict_status(in_item_t it);
    out_item_t res;
    logic signed [15:0] l, r;
    logic [63:0] st, np;
    int written;
    bit ok;
    res = '0;
    written = 0;
    if (cmd_e'(it.cmd) == CMD_PUSH) begin
      l = it.sample_left;
      r = it.is_mono ? it.sample_left : it.sample_right;
      if (it.packet_start) begin
        drop_pkt = 1'b0;
        if (it.discontinuity) clear_interp();
      end
      if (it.input_rate != 0 && out_rate != 0 && !drop_pkt) begin
        ok = 1'b1;
        if (it.input_rate == out_rate) begin
          clear_interp();
          if (store_frame(l, r)) written = 1;
          else ok = 1'b0;
        end else begin
          st = (64'(it.input_rate) << 24) / 64'(out_rate);
          if (last_in_rate != it.input_rate || last_out_rate != out_rate) begin
            have_prev = 1'b0;
            phase = '0;
            last_in_rate = it.input_rate;
            last_out_rate = out_rate;
          end
          step = st > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : st[31:0];
          if (!have_prev) begin
            have_prev = 1'b1;
          end else begin
            while (phase < PhaseOne) begin
              if (written >= MaxUpsample + 1) begin
                phase = PhaseOne;
                break;
              end
              if (!store_frame(interp(prev_l, l, phase), interp(prev_r, r, phase))) begin
                ok = 1'b0;
                break;
              end
              written++;
              np = 64'(phase) + 64'(step);
              phase = np > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : np[31:0];
            end
            if (ok) phase -= PhaseOne;
          end
          if (ok) begin
            prev_l = l;
            prev_r = r;
          end
        end
        if (!ok) begin
          ovf_cnt++;
          drop_pkt = 1'b1;
          res.overflowed = 1'b1;
        end
      end
    end else if (cmd_e'(it.cmd) == CMD_POP) begin
      if ((wr_cnt - rd_cnt) > (wr_cnt - discard_at)) rd_cnt = discard_at;
      if (rd_cnt != wr_cnt) begin
        res.out_left = ring_l[rd_cnt % RingFrames];
        res.out_right = ring_r[rd_cnt % RingFrames];
        res.pop_valid = 1'b1;
        rd_cnt++;
      end
    end else if (cmd_e'(it.cmd) == CMD_CLEAR) begin
      discard_at = wr_cnt;
      clear_interp();
    end
    res.frames_written = 6'(written);
    res.overflow_total = ovf_cnt;
    res.fill_level = 13'(readable());
    return res;
  endfunction

  // sender: bursts and gaps
  int gap_left = 0, burst_left = 0;
  bit hold_send = 1'b0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (pending_cmds.size() > 0 && !hold_send) begin
          in_item_i <= pending_cmds.pop_front();
          in_valid_i <= 1'b1;
          if (burst_left == 0) begin
            burst_left <= $urandom_range(1, 40);
            if ($urandom_range(0, 2) != 0) gap_left <= $urandom_range(0, 12);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver: stall pattern and checker
  int stall_mode = 0;
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_status.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result item %p", out_item_o);
        end else begin
          want = expected_status.pop_front();
          if (want !== out_item_o) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: expected %p got %p", want, out_item_o);
          end
        end
      end
      if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= ($urandom_range(0, 3) != 0);
        2: out_ready_i <= ($urandom_range(0, 3) == 0);
        default: out_ready_i <= ($urandom_range(0, 1) != 0);
      endcase
    end
  end

  // predictor fed at acceptance
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o)
      expected_status.push_back(predict_status(in_item_i));
  end

  task automatic write_rate(logic [RateW-1:0] v);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= '0; pwdata <= 32'(v);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    out_rate = v;
  endtask

  task automatic drain();
    while (pending_cmds.size() > 0 || in_valid_i || expected_status.size() > 0)
      @(posedge clk_i);
    repeat (120) @(posedge clk_i);
  endtask

  function automatic in_item_t rand_cmd(logic [RateW-1:0] rate, bit first);
    in_item_t it;
    int k;
    it = '0;
    k = $urandom_range(0, 99);
    if (k < 55) it.cmd = CMD_PUSH;
    else if (k < 92) it.cmd = CMD_POP;
    else if (k < 98) it.cmd = CMD_CLEAR;
    else it.cmd = CMD_NONE;
    it.sample_left = 16'($urandom());
    it.sample_right = 16'($urandom());
    it.is_mono = 1'($urandom_range(0, 1));
    it.input_rate = ($urandom_range(0, 30) == 0) ? 19'($urandom()) : rate;
    it.packet_start = first || ($urandom_range(0, 15) == 0);
    it.discontinuity = ($urandom_range(0, 7) == 0);
    return it;
  endfunction

  task automatic packets(int n, logic [RateW-1:0] rates[$]);
    logic [RateW-1:0] r;
    int len;
    while (n > 0) begin
      r = rates[$urandom_range(0, rates.size() - 1)];
      len = $urandom_range(1, 30);
      for (int i = 0; i < len && n > 0; i++, n--) pending_cmds.push_back(rand_cmd(r, i == 0));
    end
  endtask

  initial begin
    in_item_t it;
    logic [RateW-1:0] rl[$];
    for (int i = 0; i < RingFrames; i++) begin
      ring_l[i] = '0;
      ring_r[i] = '0;
    end
    out_rate = OutRateRst;
    wr_cnt = '0; rd_cnt = '0; discard_at = '0;
    prev_l = '0; prev_r = '0; step = '0;
    clear_interp();
    drop_pkt = 1'b0;
    ovf_cnt = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, all commands, empty pop, zero rate, upsample cap
    it = '0; it.cmd = CMD_POP; pending_cmds.push_back(it);
    it = '0; it.cmd = CMD_NONE; pending_cmds.push_back(it);
    it = '0; it.cmd = CMD_PUSH; it.sample_left = 16'sh7FFF; it.sample_right = 16'sh8000;
    it.input_rate = 19'd48000; it.packet_start = 1'b1; pending_cmds.push_back(it);
    it.is_mono = 1'b1; it.packet_start = 1'b0; pending_cmds.push_back(it);
    it.input_rate = '0; it.discontinuity = 1'b1; it.packet_start = 1'b1;
    pending_cmds.push_back(it);
    it = '0; it.cmd = CMD_PUSH; it.input_rate = 19'd8000; it.sample_left = 16'sh8000;
    it.sample_right = 16'sh7FFF; pending_cmds.push_back(it);
    it.sample_left = 16'sh7FFF; it.sample_right = 16'sh8000; pending_cmds.push_back(it);
    it.input_rate = 19'd1000; pending_cmds.push_back(it);
    it.sample_left = -16'sd1; pending_cmds.push_back(it);
    it.input_rate = 19'h7FFFF; it.discontinuity = 1'b1; it.packet_start = 1'b1;
    pending_cmds.push_back(it);
    it.packet_start = 1'b0; pending_cmds.push_back(it);
    it = '0; it.cmd = CMD_CLEAR; pending_cmds.push_back(it);
    it.cmd = CMD_POP; pending_cmds.push_back(it);
    pending_cmds.push_back(it);
    drain();

    write_rate(19'd384000);
    rl = '{19'd44100, 19'd384000, 19'd8000, 19'd96000};
    packets(350, rl);
    drain();

    write_rate(19'd8000);
    rl = '{19'd44100, 19'd8000, 19'd7000, 19'd384000};
    packets(350, rl);
    drain();

    // fill the ring to force overflow, then pop some frames, clear it and pop on
    write_rate(19'd48000);
    for (int i = 0; i < 160; i++) begin
      it = rand_cmd(19'd1000, i == 0);
      it.cmd = CMD_PUSH;
      it.packet_start = (i % 40 == 0);
      it.discontinuity = 1'b0;
      pending_cmds.push_back(it);
    end
    for (int i = 0; i < 30; i++) begin
      it = '0; it.cmd = (i == 10) ? CMD_CLEAR : CMD_POP;
      pending_cmds.push_back(it);
    end
    drain();

    write_rate(19'd0);
    rl = '{19'd48000, 19'd0};
    packets(100, rl);
    drain();

    write_rate(19'h7FFFF);
    rl = '{19'd48000, 19'h7FFFF, 19'd1};
    packets(200, rl);
    drain();

    write_rate(19'd44100);
    rl = '{19'd48000, 19'd44100, 19'd22050, 19'd32000};
    packets(300, rl);
    // mid-stream pause until everything is back, then continue
    while (pending_cmds.size() > 150) @(posedge clk_i);
    hold_send = 1'b1;
    @(posedge clk_i);
    while (in_valid_i || expected_status.size() > 0) @(posedge clk_i);
    hold_send = 1'b0;
    packets(400, rl);
    drain();

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("Mismatches found");
    $finish;
  end
endmodule

/* filelist.f */
+incdir+sv
sv/srrb_pkg.sv
sv/srrb_div.sv
sv/stereo_resampling_ring_buffer.sv
tb/testbench.sv
